// ===== rtl/core/ebs_pkg.sv =====
`timescale 1ns / 1ps
package ebs_pkg;

    // Sample format and stream payload
    localparam int SAMPLE_BITS = 24;
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

    // Grid geometry limits
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);

    // Configuration registers
    localparam int WIDTH_CFG_BITS  = 11;
    localparam int HEIGHT_CFG_BITS = 13;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_ADDR_BITS   = 1;
    localparam int WIDTH_RESET     = 1024;
    localparam int HEIGHT_RESET    = 1024;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Datapath widths: column sum of three, window sum of nine, magnitude
    localparam int COLSUM_BITS = SAMPLE_BITS + 2;
    localparam int SUM_BITS    = SAMPLE_BITS + 4;
    localparam int MAG_BITS    = SAMPLE_BITS + 3;

    // Exact reciprocals: floor(n * m >> k) == floor(n / d) for n < 2**MAG_BITS
    localparam int RECIP_SHIFT = MAG_BITS + 4;
    localparam int RECIP_BITS  = RECIP_SHIFT - 1;
    localparam logic [RECIP_BITS-1:0] RECIP_DIV4 =
        RECIP_BITS'(64'd1 << (RECIP_SHIFT - 2));
    localparam logic [RECIP_BITS-1:0] RECIP_DIV6 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);
    localparam logic [RECIP_BITS-1:0] RECIP_DIV9 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);
    localparam int PROD_BITS = MAG_BITS + RECIP_BITS;
    localparam int QUO_BITS  = PROD_BITS - RECIP_SHIFT;

    // Result queue
    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== rtl/core/ebs_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
module ebs_ram #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data
);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/edge_aware_box_smoother_3x3_core.sv =====
`timescale 1ns / 1ps
// 3x3 box smoother over a raster-order stream of signed height samples. Each result is the
// mean of the in-grid neighbors of one position (4 at corners, 6 on edges, 9 inside),
// truncated toward zero. Results trail the input by one row plus one sample; the last row
// of a frame drains while row 0 of the next frame streams in, and its final result has
// m_tlast set. The block takes one request per cycle while the result queue has room; a
// request at the end of a row yields two results, so the output port (one result per
// cycle) sets the sustained rate. Each result passes in order through the RAM read, the
// window sum, the magnitude, the reciprocal multiply and the queue. Two row buffers share
// one 48-bit RAM; they need no clearing after reset. Write frame_width and frame_height
// only while no request is in flight.
module edge_aware_box_smoother_3x3_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ebs_pkg::TDATA_BITS-1:0]      s_tdata,     // [23:0] height_sample
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ebs_pkg::TDATA_BITS-1:0]      m_tdata,     // [23:0] smoothed_value
    output logic                                m_tlast,     // frame_last
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [ebs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [ebs_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data
);

    localparam int S = ebs_pkg::SAMPLE_BITS;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_sel_t;

    typedef struct packed {
        logic [ebs_pkg::COL_BITS-1:0] col;
        logic                         res_first;   // result for column x-1
        logic                         res_second;  // extra result for the last column
        logic                         frame_end;   // second result closes the frame
        logic                         wide;        // first result spans three columns
        logic                         use_top;
        logic                         use_bottom;
    } item_ctl_t;

    typedef struct packed {
        logic           last;
        logic [S-1:0]   value;
    } fifo_entry_t;

    // ------------------------------------------------------------------
    // Configuration
    logic [ebs_pkg::WIDTH_CFG_BITS-1:0]  frame_width_reg;
    logic [ebs_pkg::HEIGHT_CFG_BITS-1:0] frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= ebs_pkg::WIDTH_CFG_BITS'(ebs_pkg::WIDTH_RESET);
            frame_height_reg <= ebs_pkg::HEIGHT_CFG_BITS'(ebs_pkg::HEIGHT_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ebs_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wr_data[ebs_pkg::WIDTH_CFG_BITS-1:0];
                end
                ebs_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wr_data[ebs_pkg::HEIGHT_CFG_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // Effective last column / last row, saturated to the legal range
    logic [ebs_pkg::COL_BITS-1:0] w_last;
    logic [ebs_pkg::ROW_BITS-1:0] h_last;

    always_comb begin
        if (frame_width_reg < ebs_pkg::WIDTH_CFG_BITS'(2)) begin
            w_last = ebs_pkg::COL_BITS'(1);
        end else if (frame_width_reg > ebs_pkg::WIDTH_CFG_BITS'(ebs_pkg::MAX_WIDTH)) begin
            w_last = ebs_pkg::COL_BITS'(ebs_pkg::MAX_WIDTH - 1);
        end else begin
            w_last = ebs_pkg::COL_BITS'(frame_width_reg - ebs_pkg::WIDTH_CFG_BITS'(1));
        end
        if (frame_height_reg < ebs_pkg::HEIGHT_CFG_BITS'(2)) begin
            h_last = ebs_pkg::ROW_BITS'(1);
        end else if (frame_height_reg >
                     ebs_pkg::HEIGHT_CFG_BITS'(ebs_pkg::HEIGHT_LIMIT)) begin
            h_last = ebs_pkg::ROW_BITS'(ebs_pkg::HEIGHT_LIMIT - 1);
        end else begin
            h_last = ebs_pkg::ROW_BITS'(frame_height_reg - ebs_pkg::HEIGHT_CFG_BITS'(1));
        end
    end

    // ------------------------------------------------------------------
    // Intake: position counters and request flags
    logic [ebs_pkg::COL_BITS-1:0] col_reg;
    logic [ebs_pkg::ROW_BITS-1:0] row_reg;
    logic                         flush_pending_reg;
    logic [ebs_pkg::COL_BITS-1:0] x_cur;
    logic [ebs_pkg::ROW_BITS-1:0] y_cur;
    logic                         flushing;
    logic                         active;
    logic                         accept;
    item_ctl_t                    in_ctl;

    logic [ebs_pkg::FIFO_CNT_BITS-1:0] resv_reg;

    assign x_cur    = (col_reg > w_last) ? w_last : col_reg;
    assign y_cur    = (row_reg > h_last) ? h_last : row_reg;
    assign flushing = (y_cur == '0);
    assign active   = !flushing || flush_pending_reg;
    assign s_tready = (resv_reg <= ebs_pkg::FIFO_CNT_BITS'(ebs_pkg::FIFO_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_ctl.col        = x_cur;
        in_ctl.res_first  = active && (x_cur != '0);
        in_ctl.res_second = active && (x_cur == w_last);
        in_ctl.frame_end  = flushing;
        in_ctl.wide       = (x_cur >= ebs_pkg::COL_BITS'(2));
        in_ctl.use_top    = flushing || (y_cur >= ebs_pkg::ROW_BITS'(2));
        in_ctl.use_bottom = !flushing;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg           <= '0;
            row_reg           <= '0;
            flush_pending_reg <= 1'b0;
        end else if (accept) begin
            if (x_cur == w_last) begin
                col_reg <= '0;
                if (y_cur == h_last) begin
                    row_reg           <= '0;
                    flush_pending_reg <= 1'b1;
                end else begin
                    row_reg <= y_cur + ebs_pkg::ROW_BITS'(1);
                    if (flushing) begin
                        flush_pending_reg <= 1'b0;
                    end
                end
            end else begin
                col_reg <= x_cur + ebs_pkg::COL_BITS'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Row buffers: {older row, newer row} per column
    logic               p1_valid_reg;
    item_ctl_t          p1_ctl_reg;
    logic [S-1:0]       p1_sample_reg;
    logic               p1_fwd_reg;
    logic [S-1:0]       wr_older_reg;
    logic [S-1:0]       wr_newer_reg;
    logic [2*S-1:0]     ram_rd_data;
    logic signed [S-1:0] older_rd;
    logic signed [S-1:0] newer_rd;

    ebs_ram #(
        .DATA_BITS (2 * S),
        .DEPTH     (ebs_pkg::MAX_WIDTH)
    ) u_row_ram (
        .clk     (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_ctl_reg.col),
        .wr_data ({newer_rd, p1_sample_reg}),
        .rd_addr (x_cur),
        .rd_data (ram_rd_data)
    );

    // Bypass the column written in the same cycle it was read
    assign older_rd = p1_fwd_reg ? wr_older_reg : ram_rd_data[2*S-1:S];
    assign newer_rd = p1_fwd_reg ? wr_newer_reg : ram_rd_data[S-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ctl_reg    <= in_ctl;
            p1_sample_reg <= s_tdata[S-1:0];
            p1_fwd_reg    <= p1_valid_reg && (p1_ctl_reg.col == x_cur);
        end
        if (p1_valid_reg) begin
            wr_older_reg <= newer_rd;
            wr_newer_reg <= p1_sample_reg;
        end
    end

    // ------------------------------------------------------------------
    // Window shift and masked sums
    logic signed [S-1:0]                   win_reg [9];
    logic signed [S-1:0]                   win_next [9];
    logic signed [ebs_pkg::COLSUM_BITS-1:0] col_sum [3];
    logic signed [ebs_pkg::SUM_BITS-1:0]   sum_next [2];
    div_sel_t                              div_next [2];
    logic                                  rows3;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            win_next[k] = win_reg[k+3];
        end
        win_next[6] = older_rd;
        win_next[7] = newer_rd;
        win_next[8] = p1_sample_reg;
        for (int c = 0; c < 3; c++) begin
            col_sum[c] = ebs_pkg::COLSUM_BITS'(win_next[3*c+1])
                       + (p1_ctl_reg.use_top ? ebs_pkg::COLSUM_BITS'(win_next[3*c])
                                             : '0)
                       + (p1_ctl_reg.use_bottom ? ebs_pkg::COLSUM_BITS'(win_next[3*c+2])
                                                : '0);
        end
        sum_next[1] = ebs_pkg::SUM_BITS'(col_sum[1]) + ebs_pkg::SUM_BITS'(col_sum[2]);
        sum_next[0] = sum_next[1]
                    + (p1_ctl_reg.wide ? ebs_pkg::SUM_BITS'(col_sum[0]) : '0);
        rows3       = p1_ctl_reg.use_top && p1_ctl_reg.use_bottom;
        div_next[1] = rows3 ? DIV_BY_6 : DIV_BY_4;
        if (p1_ctl_reg.wide) begin
            div_next[0] = rows3 ? DIV_BY_9 : DIV_BY_6;
        end else begin
            div_next[0] = div_next[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (p1_valid_reg) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divide by neighbor count: magnitude, reciprocal multiply, sign restore
    logic                                 p2_valid_reg;
    logic [1:0]                           p2_res_reg;
    logic                                 p2_last_reg;
    logic signed [ebs_pkg::SUM_BITS-1:0]  p2_sum_reg [2];
    div_sel_t                             p2_div_reg [2];

    logic                                 p3_valid_reg;
    logic [1:0]                           p3_res_reg;
    logic                                 p3_last_reg;
    logic [ebs_pkg::MAG_BITS-1:0]         p3_mag_reg [2];
    logic [ebs_pkg::RECIP_BITS-1:0]       p3_recip_reg [2];
    logic [1:0]                           p3_neg_reg;

    logic                                 p4_valid_reg;
    logic [1:0]                           p4_res_reg;
    logic                                 p4_last_reg;
    logic [ebs_pkg::PROD_BITS-1:0]        p4_prod_reg [2];
    logic [1:0]                           p4_neg_reg;

    logic [ebs_pkg::MAG_BITS-1:0]         mag_next [2];
    logic [ebs_pkg::RECIP_BITS-1:0]       recip_next [2];
    logic [ebs_pkg::QUO_BITS-1:0]         quo [2];
    logic [ebs_pkg::QUO_BITS-1:0]         quo_signed [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (p2_sum_reg[l][ebs_pkg::SUM_BITS-1]) begin
                mag_next[l] = ebs_pkg::MAG_BITS'(-p2_sum_reg[l]);
            end else begin
                mag_next[l] = ebs_pkg::MAG_BITS'(p2_sum_reg[l]);
            end
            case (p2_div_reg[l])
                DIV_BY_4: recip_next[l] = ebs_pkg::RECIP_DIV4;
                DIV_BY_6: recip_next[l] = ebs_pkg::RECIP_DIV6;
                DIV_BY_9: recip_next[l] = ebs_pkg::RECIP_DIV9;
                default:  recip_next[l] = ebs_pkg::RECIP_DIV4;
            endcase
            quo[l]        = p4_prod_reg[l][ebs_pkg::PROD_BITS-1:ebs_pkg::RECIP_SHIFT];
            quo_signed[l] = p4_neg_reg[l] ? -quo[l] : quo[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p2_res_reg  <= {p1_ctl_reg.res_second, p1_ctl_reg.res_first};
        p2_last_reg <= p1_ctl_reg.frame_end;
        p3_res_reg  <= p2_res_reg;
        p3_last_reg <= p2_last_reg;
        p4_res_reg  <= p3_res_reg;
        p4_last_reg <= p3_last_reg;
        for (int l = 0; l < 2; l++) begin
            p2_sum_reg[l]   <= sum_next[l];
            p2_div_reg[l]   <= div_next[l];
            p3_mag_reg[l]   <= mag_next[l];
            p3_recip_reg[l] <= recip_next[l];
            p3_neg_reg[l]   <= p2_sum_reg[l][ebs_pkg::SUM_BITS-1];
            p4_prod_reg[l]  <= ebs_pkg::PROD_BITS'(p3_mag_reg[l])
                             * ebs_pkg::PROD_BITS'(p3_recip_reg[l]);
            p4_neg_reg[l]   <= p3_neg_reg[l];
        end
    end

    // ------------------------------------------------------------------
    // Result queue; slots are reserved on intake so the pipeline never stalls
    fifo_entry_t                        fifo_reg [ebs_pkg::FIFO_DEPTH];
    logic [ebs_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_reg;
    logic [ebs_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_reg;
    logic [ebs_pkg::FIFO_CNT_BITS-1:0]  cnt_reg;
    logic [ebs_pkg::FIFO_CNT_BITS-1:0]  cnt_next;
    logic [ebs_pkg::FIFO_CNT_BITS-1:0]  resv_next;
    logic                               wr_first;
    logic                               wr_second;
    logic [ebs_pkg::FIFO_PTR_BITS-1:0]  wr_addr_second;
    logic [ebs_pkg::FIFO_CNT_BITS-1:0]  n_written;
    logic [ebs_pkg::FIFO_CNT_BITS-1:0]  n_released;
    logic                               pop;

    assign wr_first       = p4_valid_reg && p4_res_reg[0];
    assign wr_second      = p4_valid_reg && p4_res_reg[1];
    assign wr_addr_second = wr_ptr_reg + ebs_pkg::FIFO_PTR_BITS'(wr_first);
    assign n_written      = ebs_pkg::FIFO_CNT_BITS'(wr_first)
                          + ebs_pkg::FIFO_CNT_BITS'(wr_second);
    assign n_released     = p4_valid_reg ? ebs_pkg::FIFO_CNT_BITS'(2) - n_written : '0;
    assign pop            = m_tvalid && m_tready;
    assign cnt_next       = cnt_reg + n_written - ebs_pkg::FIFO_CNT_BITS'(pop);
    assign resv_next      = resv_reg
                          + (accept ? ebs_pkg::FIFO_CNT_BITS'(2) : '0)
                          - n_released
                          - ebs_pkg::FIFO_CNT_BITS'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            resv_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + ebs_pkg::FIFO_PTR_BITS'(n_written);
            rd_ptr_reg <= rd_ptr_reg + ebs_pkg::FIFO_PTR_BITS'(pop);
            cnt_reg    <= cnt_next;
            resv_reg   <= resv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_first) begin
            fifo_reg[wr_ptr_reg] <= '{last: 1'b0, value: quo_signed[0][S-1:0]};
        end
        if (wr_second) begin
            fifo_reg[wr_addr_second] <= '{last: p4_last_reg, value: quo_signed[1][S-1:0]};
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = ebs_pkg::TDATA_BITS'(fifo_reg[rd_ptr_reg].value);
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

endmodule

// ===== rtl/core/ebs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the box smoother core.
module ebs_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ebs_pkg::TDATA_BITS-1:0]      m_tdata,
    input logic                                m_tlast
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Intake only closes when the result queue is backed up
    a_stall_has_results: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // A stalled result holds its value
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Input is open once reset has released
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> s_tready)
        else $error("input not ready after reset");

endmodule

bind edge_aware_box_smoother_3x3_core ebs_checker u_ebs_checker (.*);
